### design/csc_pkg.sv
package csc_pkg;

	localparam logic        CMD_DECODE    = 1'b0;
	localparam logic        CMD_ENCODE    = 1'b1;

	localparam logic [11:0] EPOCH_YEAR    = 12'd2000;
	localparam logic [3:0]  MONTH_LIMIT   = 4'd13;
	localparam logic [8:0]  DAYS_LEAP     = 9'd366;
	localparam logic [8:0]  DAYS_NORM     = 9'd365;
	localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
	localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SEC_PER_MIN   = 17'd60;
	localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
	localparam logic [20:0] WDAY_OFS_DEC  = 21'd6;
	localparam logic [20:0] WDAY_OFS_ENC  = 21'd12;
	localparam logic [1:0]  YR_MOD4_LAST  = 2'd3;
	localparam logic [6:0]  YR_MOD100_LAST = 7'd99;
	localparam logic [8:0]  YR_MOD400_LAST = 9'd399;

	// floor(x / d) = (x * ceil(2^k / d)) >> k over the operand range of each division
	localparam logic [25:0] RCP_DAYS      = 26'd50903317;
	localparam logic [25:0] RCP_WDAY      = 26'd2396746;
	localparam logic [25:0] RCP_HOUR      = 26'd9321;
	localparam logic [25:0] RCP_MIN       = 26'd1093;
	localparam int          SH_DAYS       = 35;
	localparam int          SH_WDAY       = 24;
	localparam int          SH_HOUR       = 21;
	localparam int          SH_MIN        = 14;

	// y is a multiple of 25 exactly when y * inv(25) mod 2^12 <= (2^12 - 1) / 25
	localparam logic [11:0] INV25         = 12'd3113;
	localparam logic [11:0] DIV25_MAX     = 12'd163;

	localparam int          QDEPTH        = 2;
	localparam int          QAW           = 1;

	typedef enum logic [1:0] {
		DIV_OP_DAYS = 2'd0,
		DIV_OP_WDAY = 2'd1,
		DIV_OP_HOUR = 2'd2,
		DIV_OP_MIN  = 2'd3
	} div_op_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] count_in;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] count_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [2:0]  weekday;
	} out_item_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] count;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        leap;
		logic [11:0] nyears;
		logic [3:0]  mlimit;
	} job_t;

	typedef struct packed {
		logic        go;
		div_op_t     op;
		logic [31:0] num;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [20:0] quo;
		logic [16:0] rem;
	} div_rsp_t;

	function automatic logic leap_year(input logic [11:0] y);
		logic [23:0] prod;
		logic        div25;
		prod  = 24'(y) * 24'(INV25);
		div25 = (prod[11:0] <= DIV25_MAX);
		return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### design/csc_front.sv
module csc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  csc_pkg::in_item_t in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output csc_pkg::job_t     push_data
);
	import csc_pkg::*;

	logic valid_s1;
	job_t job_s1;
	job_t job_next;

	always_comb begin
		job_next.cmd    = in_data.cmd;
		job_next.count  = in_data.count_in;
		job_next.year   = in_data.year_in;
		job_next.month  = in_data.month_in;
		job_next.day    = in_data.day_in;
		job_next.hour   = in_data.hour_in;
		job_next.minute = in_data.minute_in;
		job_next.second = in_data.second_in;
		job_next.leap   = leap_year(in_data.year_in);
		job_next.nyears = (in_data.year_in > EPOCH_YEAR) ? (in_data.year_in - EPOCH_YEAR) : '0;
		job_next.mlimit = (in_data.month_in > MONTH_LIMIT) ? MONTH_LIMIT : in_data.month_in;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_next;
		end
	end

endmodule

### design/csc_queue.sv
module csc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  csc_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output csc_pkg::job_t pop_data
);
	import csc_pkg::*;

	job_t           mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

### design/csc_div.sv
module csc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csc_pkg::div_req_t req,
	output csc_pkg::div_rsp_t rsp
);
	import csc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  cnt_q;
	div_op_t     op_q;
	logic [31:0] num_q;
	logic [50:0] prod_q;
	logic [20:0] quo_q;
	logic [16:0] rem_q;
	logic [24:0] mul_a;
	logic [25:0] mul_m;
	logic [20:0] quo_next;
	logic [16:0] dvsr;
	logic [37:0] back_prod;

	always_comb begin
		case (op_q)
			DIV_OP_DAYS: begin
				mul_a    = num_q[31:7];
				mul_m    = RCP_DAYS;
				quo_next = 21'(prod_q >> SH_DAYS);
				dvsr     = SEC_PER_DAY;
			end
			DIV_OP_HOUR: begin
				mul_a    = 25'(num_q[16:4]);
				mul_m    = RCP_HOUR;
				quo_next = 21'(prod_q >> SH_HOUR);
				dvsr     = SEC_PER_HOUR;
			end
			DIV_OP_MIN: begin
				mul_a    = 25'(num_q[11:2]);
				mul_m    = RCP_MIN;
				quo_next = 21'(prod_q >> SH_MIN);
				dvsr     = SEC_PER_MIN;
			end
			default: begin
				mul_a    = 25'(num_q[20:0]);
				mul_m    = RCP_WDAY;
				quo_next = 21'(prod_q >> SH_WDAY);
				dvsr     = DAYS_PER_WEEK;
			end
		endcase
	end

	assign back_prod = 38'(quo_q) * 38'(dvsr);

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go && !busy_q) begin
			op_q  <= req.op;
			num_q <= req.num;
		end else if (busy_q) begin
			case (cnt_q)
				2'd0: begin
					prod_q <= 51'(mul_a) * 51'(mul_m);
				end
				2'd1: begin
					quo_q <= quo_next;
				end
				2'd2: begin
					rem_q <= 17'(num_q - back_prod[31:0]);
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q)
		else $error("divide started while busy");
`endif

endmodule

### design/csc_back.sv
module csc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  csc_pkg::job_t      pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output csc_pkg::out_item_t out_data
);
	import csc_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_DIV_DAYS = 12'b000000000010,
		ST_DIV_WDAY = 12'b000000000100,
		ST_DIV_HOUR = 12'b000000001000,
		ST_DIV_MIN  = 12'b000000010000,
		ST_YEAR_DEC = 12'b000000100000,
		ST_MON_DEC  = 12'b000001000000,
		ST_YEAR_ENC = 12'b000010000000,
		ST_MON_ENC  = 12'b000100000000,
		ST_MUL      = 12'b001000000000,
		ST_SUM      = 12'b010000000000,
		ST_DONE     = 12'b100000000000
	} state_t;

	state_t      state_q;
	logic        go_sent_q;
	logic        out_valid_q;
	out_item_t   out_q;

	job_t        job_q;
	logic [19:0] acc_q;
	logic [16:0] sod_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [1:0]  y4_q;
	logic [6:0]  y100_q;
	logic [8:0]  y400_q;
	logic [11:0] nyr_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [2:0]  wd_q;
	logic [31:0] prod_q;
	logic [16:0] tod_q;
	logic [31:0] count_q;

	div_req_t    req;
	div_rsp_t    rsp;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen_dec;
	logic [4:0]  mlen_enc;
	logic [36:0] prod_full;
	logic [16:0] tod_next;
	logic        out_free;
	out_item_t   res;

	csc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign leap      = (y4_q == '0) && ((y100_q != '0) || (y400_q == '0));
	assign ylen      = leap ? DAYS_LEAP : DAYS_NORM;
	assign mlen_dec  = month_len(month_q) + 5'((month_q == 4'd2) && leap);
	assign mlen_enc  = month_len(month_q) + 5'((month_q == 4'd2) && job_q.leap);
	assign prod_full = 37'(acc_q) * 37'(SEC_PER_DAY);
	assign tod_next  = 17'(job_q.hour) * SEC_PER_HOUR + 17'(job_q.minute) * SEC_PER_MIN
		+ 17'(job_q.second);
	assign out_free  = !out_valid_q || out_ready;
	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		req.go  = 1'b0;
		req.op  = DIV_OP_WDAY;
		req.num = '0;
		case (state_q)
			ST_DIV_DAYS: begin
				req.go  = !go_sent_q;
				req.op  = DIV_OP_DAYS;
				req.num = job_q.count;
			end
			ST_DIV_WDAY: begin
				req.go  = !go_sent_q;
				req.op  = DIV_OP_WDAY;
				req.num = 32'(21'(acc_q)
					+ ((job_q.cmd == CMD_ENCODE) ? WDAY_OFS_ENC : WDAY_OFS_DEC));
			end
			ST_DIV_HOUR: begin
				req.go  = !go_sent_q;
				req.op  = DIV_OP_HOUR;
				req.num = 32'(sod_q);
			end
			ST_DIV_MIN: begin
				req.go  = !go_sent_q;
				req.op  = DIV_OP_MIN;
				req.num = 32'(sod_q);
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (job_q.cmd == CMD_ENCODE) begin
			res.count_out  = count_q;
			res.year_out   = job_q.year;
			res.month_out  = job_q.month;
			res.day_out    = job_q.day;
			res.hour_out   = job_q.hour;
			res.minute_out = job_q.minute;
			res.second_out = job_q.second;
		end else begin
			res.count_out  = job_q.count;
			res.year_out   = year_q;
			res.month_out  = month_q;
			res.day_out    = acc_q[4:0] + 5'd1;
			res.hour_out   = hour_q;
			res.minute_out = min_q;
			res.second_out = sec_q;
		end
		res.weekday = wd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_sent_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.go) begin
				go_sent_q <= 1'b1;
			end
			if (rsp.done) begin
				go_sent_q <= 1'b0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= (pop_data.cmd == CMD_ENCODE) ? ST_YEAR_ENC : ST_DIV_DAYS;
					end
				end
				ST_DIV_DAYS: begin
					if (rsp.done) begin
						state_q <= ST_DIV_WDAY;
					end
				end
				ST_DIV_WDAY: begin
					if (rsp.done) begin
						state_q <= (job_q.cmd == CMD_ENCODE) ? ST_MUL : ST_DIV_HOUR;
					end
				end
				ST_DIV_HOUR: begin
					if (rsp.done) begin
						state_q <= ST_DIV_MIN;
					end
				end
				ST_DIV_MIN: begin
					if (rsp.done) begin
						state_q <= ST_YEAR_DEC;
					end
				end
				ST_YEAR_DEC: begin
					if (acc_q < 20'(ylen)) begin
						state_q <= ST_MON_DEC;
					end
				end
				ST_MON_DEC: begin
					if (acc_q < 20'(mlen_dec)) begin
						state_q <= ST_DONE;
					end
				end
				ST_YEAR_ENC: begin
					if (nyr_q == '0) begin
						state_q <= ST_MON_ENC;
					end
				end
				ST_MON_ENC: begin
					if (month_q >= job_q.mlimit) begin
						state_q <= ST_DIV_WDAY;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					job_q   <= pop_data;
					acc_q   <= '0;
					year_q  <= EPOCH_YEAR;
					month_q <= 4'd1;
					y4_q    <= '0;
					y100_q  <= '0;
					y400_q  <= '0;
					nyr_q   <= pop_data.nyears;
				end
			end
			ST_DIV_DAYS: begin
				if (rsp.done) begin
					acc_q <= rsp.quo[19:0];
					sod_q <= rsp.rem;
				end
			end
			ST_DIV_WDAY: begin
				if (rsp.done) begin
					wd_q <= rsp.rem[2:0];
				end
			end
			ST_DIV_HOUR: begin
				if (rsp.done) begin
					hour_q <= rsp.quo[4:0];
					sod_q  <= rsp.rem;
				end
			end
			ST_DIV_MIN: begin
				if (rsp.done) begin
					min_q <= rsp.quo[5:0];
					sec_q <= rsp.rem[5:0];
				end
			end
			ST_YEAR_DEC, ST_YEAR_ENC: begin
				if ((state_q == ST_YEAR_DEC) ? (acc_q >= 20'(ylen)) : (nyr_q != '0)) begin
					acc_q  <= (state_q == ST_YEAR_DEC) ? (acc_q - 20'(ylen)) : (acc_q + 20'(ylen));
					nyr_q  <= nyr_q - 1'b1;
					year_q <= year_q + 1'b1;
					y4_q   <= y4_q + 1'b1;
					y100_q <= (y100_q == YR_MOD100_LAST) ? '0 : (y100_q + 1'b1);
					y400_q <= (y400_q == YR_MOD400_LAST) ? '0 : (y400_q + 1'b1);
				end
			end
			ST_MON_DEC: begin
				if (acc_q >= 20'(mlen_dec)) begin
					acc_q   <= acc_q - 20'(mlen_dec);
					month_q <= month_q + 1'b1;
				end
			end
			ST_MON_ENC: begin
				if (month_q >= job_q.mlimit) begin
					acc_q <= acc_q + 20'(job_q.day);
				end else begin
					acc_q   <= acc_q + 20'(mlen_enc);
					month_q <= month_q + 1'b1;
				end
			end
			ST_MUL: begin
				prod_q <= prod_full[31:0];
				tod_q  <= tod_next;
			end
			ST_SUM: begin
				count_q <= prod_q + 32'(tod_q) - 32'(SEC_PER_DAY);
			end
			ST_DONE: begin
				if (out_free) begin
					out_q <= res;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

`ifndef SYNTH
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MON_DEC) |-> (month_q >= 4'd1 && month_q <= 4'd12))
		else $error("decode month out of range");
`endif

endmodule

### design/calendar_seconds_converter.sv
// Channel   Signals                        Payload
// input     in_valid / in_ready            in_data  (cmd, count or date and time)
// output    out_valid / out_ready          out_data (count, date, time, weekday)
//
// Decode first divides out days, weekday, hours and minutes; encode ends with a weekday
// division, a multiply and a sum. Both walk the years, then the months, one step per cycle.
// Each constant division is a reciprocal multiply, then a shift for the quotient and a
// back-multiply for the remainder. The front stage and queue sit ahead of the back end.
// Reset arst_n clears all control state; no clearing pass is needed. A result waiting for
// out_ready holds the back end while the front stage and two-entry queue accept until full.
module calendar_seconds_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output csc_pkg::out_item_t out_data
);
	import csc_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	csc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	csc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	csc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
